// File: hw/rtl/ttcs_pkg.sv
// ----------------------------------------------------------------------------
// ttcs_pkg: shared definitions for the text terminal block
// Screen geometry, character codes, register map and item types.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcs_pkg;

    // Screen geometry
    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int CELL_ADDR_W    = $clog2(CELL_COUNT);
    localparam int ROW_W          = $clog2(SCREEN_ROWS);
    localparam int COL_W          = $clog2(SCREEN_COLUMNS);
    localparam int CELL_W         = 16;

    // Character codes
    localparam logic [7:0] CODE_BACKSPACE  = 8'd8;
    localparam logic [7:0] CODE_NEWLINE    = 8'd10;
    localparam logic [7:0] CODE_SPACE      = 8'd32;
    localparam logic [7:0] RESET_ATTRIBUTE = 8'h0F;

    // Item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Register map
    localparam int          PADDR_W            = 2;
    localparam logic [1:0]  REG_TEXT_ATTRIBUTE = 2'd0;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } req_t;

    typedef struct packed {
        logic [4:0]  out_row;
        logic [6:0]  out_column;
        logic [15:0] cell_value;
    } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/ttcs_ram.sv
// ----------------------------------------------------------------------------
// ttcs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/text_terminal_cursor_scroll_top.sv
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_top: text-cell terminal with cursor and scroll
// Screen store in one RAM, cursor and scroll offset in registers.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen RAM once, writing a blank cell
// (space, attribute 0x0F) per cycle, taking no item until all SCREEN_ROWS *
// SCREEN_COLUMNS = 2000 cells are written; the APB port works in that pass.
// Then it works on one item at a time: a character write does its RAM write,
// if any, an out-of-screen read makes no RAM access, and an in-screen read
// issues the RAM read and captures the registered read data. A write that
// moves the cursor past the last row scrolls by advancing a row offset into
// the RAM, which is circular in rows, and then blanks the new bottom row at
// one cell per cycle through the single write port. Each item ends by loading
// the output register once it is free; a result waiting in the output register
// does not block acceptance of the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_cursor_scroll_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire ttcs_pkg::req_t                req,
    // result channel
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output ttcs_pkg::rsp_t                     rsp,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ttcs_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    import ttcs_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_RDATA  = 5'b00100,
        ST_BLANK  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    localparam logic [ROW_W-1:0]       LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0]       LAST_COL  = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [CELL_ADDR_W-1:0] LAST_CELL = CELL_ADDR_W'(CELL_COUNT - 1);

    // Physical row of a screen row, given the scroll offset
    function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, base};
        if (sum >= (ROW_W+1)'(SCREEN_ROWS))
        begin
            sum = sum - (ROW_W+1)'(SCREEN_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // RAM address of a physical row and column
    function automatic logic [CELL_ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                         input logic [COL_W-1:0] col);
        return CELL_ADDR_W'(row) * CELL_ADDR_W'(SCREEN_COLUMNS) + CELL_ADDR_W'(col);
    endfunction

    state_t                 state_reg, state_next;
    logic [ROW_W-1:0]       cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]       cursor_col_reg, cursor_col_next;
    logic [ROW_W-1:0]       base_row_reg, base_row_next;
    logic [7:0]             attr_reg;
    logic [CELL_ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ROW_W-1:0]       blank_row_reg, blank_row_next;
    logic [COL_W-1:0]       blank_col_reg, blank_col_next;
    logic [CELL_W-1:0]      res_cell_reg, res_cell_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    logic                   req_accept;
    logic                   cfg_write;
    logic [CELL_W-1:0]      blank_cell;
    logic [ROW_W-1:0]       cursor_phys_row;
    logic [ROW_W-1:0]       read_phys_row;
    logic                   read_in_range;
    logic [COL_W:0]         col_inc;

    logic                   mem_we;
    logic [CELL_ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0]      mem_wdata;
    logic                   mem_re;
    logic [CELL_ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0]      mem_rdata;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == REG_TEXT_ATTRIBUTE);
    assign prdata    = (paddr == REG_TEXT_ATTRIBUTE) ? {24'd0, attr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTRIBUTE;
        end
        else if (cfg_write)
        begin
            attr_reg <= pwdata[7:0];
        end
    end

    // Handshake and shared decode
    assign req_stall       = (state_reg != ST_IDLE);
    assign req_accept      = req_valid && !req_stall;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;
    assign blank_cell      = {attr_reg, CODE_SPACE};
    assign cursor_phys_row = wrap_row(cursor_row_reg, base_row_reg);
    assign read_in_range   = (int'(req.read_row) < SCREEN_ROWS)
                             && (int'(req.read_column) < SCREEN_COLUMNS);
    assign read_phys_row   = wrap_row(ROW_W'(req.read_row), base_row_reg);
    assign col_inc         = {1'b0, cursor_col_reg} + (COL_W+1)'(1);

    // Sequence item work and drive the RAM ports
    always_comb
    begin
        state_next      = state_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        base_row_next   = base_row_reg;
        clr_cnt_next    = clr_cnt_reg;
        blank_row_next  = blank_row_reg;
        blank_col_next  = blank_col_reg;
        res_cell_next   = res_cell_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        mem_waddr       = cell_addr(cursor_phys_row, cursor_col_reg);
        mem_wdata       = blank_cell;
        mem_re          = 1'b0;
        mem_raddr       = cell_addr(read_phys_row, COL_W'(req.read_column));

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = {RESET_ATTRIBUTE, CODE_SPACE};
                clr_cnt_next = clr_cnt_reg + CELL_ADDR_W'(1);
                if (clr_cnt_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_accept)
                begin
                    res_cell_next = '0;
                    state_next    = ST_FINISH;
                    if (req.mode == MODE_READ)
                    begin
                        if (read_in_range)
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_RDATA;
                        end
                    end
                    else if (req.char_code == CODE_BACKSPACE)
                    begin
                        if (cursor_col_reg != '0)
                        begin
                            cursor_col_next = cursor_col_reg - COL_W'(1);
                            mem_we          = 1'b1;
                            mem_waddr       = cell_addr(cursor_phys_row, cursor_col_next);
                        end
                    end
                    else
                    begin
                        // store the character unless it is a newline
                        if (req.char_code != CODE_NEWLINE)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {attr_reg, req.char_code};
                        end
                        if (req.char_code == CODE_NEWLINE
                            || col_inc == (COL_W+1)'(SCREEN_COLUMNS))
                        begin
                            cursor_col_next = '0;
                            if (cursor_row_reg == LAST_ROW)
                            begin
                                // scroll: old top row becomes the blank bottom row
                                blank_row_next = base_row_reg;
                                blank_col_next = '0;
                                base_row_next  = wrap_row(base_row_reg, ROW_W'(1));
                                state_next     = ST_BLANK;
                            end
                            else
                            begin
                                cursor_row_next = cursor_row_reg + ROW_W'(1);
                            end
                        end
                        else
                        begin
                            cursor_col_next = col_inc[COL_W-1:0];
                        end
                    end
                end
            end

            ST_RDATA:
            begin
                res_cell_next = mem_rdata;
                state_next    = ST_FINISH;
            end

            ST_BLANK:
            begin
                mem_we         = 1'b1;
                mem_waddr      = cell_addr(blank_row_reg, blank_col_reg);
                blank_col_next = blank_col_reg + COL_W'(1);
                if (blank_col_reg == LAST_COL)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // load the result once the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.out_row    = 5'(cursor_row_reg);
                    rsp_next.out_column = 7'(cursor_col_reg);
                    rsp_next.cell_value = res_cell_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            base_row_reg   <= '0;
            clr_cnt_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            base_row_reg   <= base_row_next;
            clr_cnt_reg    <= clr_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        blank_row_reg <= blank_row_next;
        blank_col_reg <= blank_col_next;
        res_cell_reg  <= res_cell_next;
        rsp_reg       <= rsp_next;
    end

    // Screen store
    ttcs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_row_reg < LAST_ROW + ROW_W'(1)) || (cursor_row_reg == LAST_ROW))
        else $error("cursor row beyond last screen row");

    assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cursor_col_reg) < SCREEN_COLUMNS) && (int'(base_row_reg) < SCREEN_ROWS))
        else $error("cursor column or scroll offset out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLANK) |-> (cursor_row_reg == LAST_ROW) && (cursor_col_reg == '0))
        else $error("bottom row blanked while cursor is not at its start");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_RDATA) && (state_reg != ST_FINISH))
        else $error("screen write outside a write phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDATA) |-> $past(mem_re))
        else $error("read data taken without a read issued");

endmodule

`default_nettype wire

// File: tb/text_terminal_cursor_scroll_top_test.sv
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_top_test: self-checking bench for the terminal
// Drives character writes and cell reads through the valid/stall request
// channel, tracks screen contents and cursor in a scoreboard, and compares
// every result field. Covers wrap, newline, backspace, scroll, out-of-screen
// reads and several text attribute settings, with and without random sender
// and receiver idling.
// ----------------------------------------------------------------------------
`default_nettype none

import ttcs_pkg::*;

// Tracks the screen and cursor, and holds the results still to come
class screen_tracker;
    bit [15:0]   cells [CELL_COUNT];
    bit [31:0]   row;
    bit [31:0]   col;
    logic [7:0]  attr;
    rsp_t        awaited_reports [$];
    int unsigned errors;
    int unsigned items_taken;
    int unsigned reports_seen;
    int unsigned cell_reads;
    int unsigned scrolls;

    function new();
        for (int i = 0; i < CELL_COUNT; i++)
            cells[i] = {RESET_ATTRIBUTE, CODE_SPACE};
        row = 0;
        col = 0;
        attr = RESET_ATTRIBUTE;
        errors = 0;
        items_taken = 0;
        reports_seen = 0;
        cell_reads = 0;
        scrolls = 0;
    endfunction

    function void set_attribute(logic [7:0] value);
        attr = value;
    endfunction

    function int pending();
        return awaited_reports.size();
    endfunction

    // Move to column 0 of the next row, scrolling off the bottom
    function void advance_row();
        col = 0;
        row++;
        if (row >= SCREEN_ROWS) begin
            for (int i = 0; i + SCREEN_COLUMNS < CELL_COUNT; i++)
                cells[i] = cells[i + SCREEN_COLUMNS];
            for (int i = 0; i < SCREEN_COLUMNS; i++)
                cells[(SCREEN_ROWS - 1) * SCREEN_COLUMNS + i] = {attr, CODE_SPACE};
            row = SCREEN_ROWS - 1;
            scrolls++;
        end
    endfunction

    // Apply one accepted item and queue the result it causes
    function void apply_item(req_t it);
        rsp_t r;
        r = '0;
        items_taken++;
        if (it.mode == MODE_WRITE) begin
            if (it.char_code == CODE_BACKSPACE) begin
                if (col > 0) begin
                    col--;
                    cells[row * SCREEN_COLUMNS + col] = {attr, CODE_SPACE};
                end
            end else if (it.char_code == CODE_NEWLINE) begin
                advance_row();
            end else begin
                cells[row * SCREEN_COLUMNS + col] = {attr, it.char_code};
                col++;
                if (col >= SCREEN_COLUMNS)
                    advance_row();
            end
        end else begin
            cell_reads++;
            if (it.read_row < SCREEN_ROWS && it.read_column < SCREEN_COLUMNS)
                r.cell_value = cells[it.read_row * SCREEN_COLUMNS + it.read_column];
        end
        r.out_row = row[4:0];
        r.out_column = col[6:0];
        awaited_reports.push_back(r);
    endfunction

    function void flag(string field, int unsigned want, int unsigned got);
        errors++;
        if (errors <= 40)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_report(rsp_t got);
        rsp_t want;
        reports_seen++;
        if (awaited_reports.size() == 0) begin
            errors++;
            if (errors <= 40)
                $display("%0t: unexpected result: expected none, got row %0d col %0d cell 0x%h",
                         $time, got.out_row, got.out_column, got.cell_value);
            return;
        end
        want = awaited_reports.pop_front();
        if (got.out_row !== want.out_row)
            flag("out_row", want.out_row, got.out_row);
        if (got.out_column !== want.out_column)
            flag("out_column", want.out_column, got.out_column);
        if (got.cell_value !== want.cell_value)
            flag("cell_value", want.cell_value, got.cell_value);
    endfunction
endclass

module text_terminal_cursor_scroll_top_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 317;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    req_t                req       = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    rsp_t                rsp;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    screen_tracker sb;
    int unsigned   send_idle_pct;
    int unsigned   take_stall_pct;
    int unsigned   config_errors;
    int unsigned   quiet_cycles;
    int unsigned   settings_used;

    text_terminal_cursor_scroll_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Take results, check them, and stall at random
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_report(rsp);
        rsp_stall <= (take_stall_pct != 0) && ($urandom_range(0, 99) < take_stall_pct);
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task send_item(input req_t it);
        int unsigned gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sb.apply_item(it);
    endtask

    function req_t make_write(input logic [7:0] ch);
        req_t it;
        it.mode = MODE_WRITE;
        it.char_code = ch;
        it.read_row = 5'($urandom_range(0, 31));
        it.read_column = 7'($urandom_range(0, 127));
        return it;
    endfunction

    function req_t make_read(input int unsigned r, input int unsigned c);
        req_t it;
        it.mode = MODE_READ;
        it.char_code = 8'($urandom_range(0, 255));
        it.read_row = r[4:0];
        it.read_column = c[6:0];
        return it;
    endfunction

    // Write the attribute register, then read it back
    task program_attribute(input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_TEXT_ATTRIBUTE;
        pwdata <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_attribute(value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[7:0] !== value) begin
            config_errors++;
            $display("%0t: text_attribute readback: expected 0x%h, got 0x%h",
                     $time, value, prdata[7:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    // Drop valid and hold until every result has come back
    task settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Random text: lines, long lines that wrap, backspaces, reads and noise
    task run_text_phase(input int unsigned quota);
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        int unsigned r;
        int unsigned c;
        logic [7:0]  ch;
        req_t        it;
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(75, 90)
                                                  : $urandom_range(0, 30);
                for (int i = 0; i < len; i++) begin
                    ch = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(8'h20, 8'h7E));
                    send_item(make_write(ch));
                    sent++;
                end
                if ($urandom_range(0, 9) < 7) begin
                    send_item(make_write(CODE_NEWLINE));
                    sent++;
                end
            end else if (kind <= 6) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    send_item(make_write(CODE_BACKSPACE));
                    sent++;
                end
            end else if (kind <= 8) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 4))
                        0: begin
                            if ($urandom_range(0, 1) == 0) begin
                                r = $urandom_range(SCREEN_ROWS, 31);
                                c = $urandom_range(0, 127);
                            end else begin
                                r = $urandom_range(0, 31);
                                c = $urandom_range(SCREEN_COLUMNS, 127);
                            end
                        end
                        1, 2: begin
                            r = $urandom_range((sb.row > 0) ? sb.row - 1 : 0, sb.row);
                            c = $urandom_range(0, sb.col);
                        end
                        default: begin
                            r = $urandom_range(0, SCREEN_ROWS - 1);
                            c = $urandom_range(0, SCREEN_COLUMNS - 1);
                        end
                    endcase
                    send_item(make_read(r, c));
                    sent++;
                end
            end else begin
                it.mode = 1'($urandom_range(0, 1));
                it.char_code = 8'($urandom_range(0, 255));
                it.read_row = 5'($urandom_range(0, 31));
                it.read_column = 7'($urandom_range(0, 127));
                send_item(it);
                sent++;
            end
        end
        settle();
    endtask

    initial
    begin
        logic [7:0] attr_plan [6];
        sb = new();
        send_idle_pct = 0;
        take_stall_pct = 0;
        config_errors = 0;
        quiet_cycles = 0;
        settings_used = 0;
        attr_plan = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h00, 8'h0F};
        attr_plan[4] = 8'($urandom_range(0, 255));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset contents, screen edges, backspace, control bytes
        send_idle_pct = 25;
        take_stall_pct = 50;
        send_item(make_read(0, 0));
        send_item(make_read(SCREEN_ROWS - 1, SCREEN_COLUMNS - 1));
        send_item(make_read(SCREEN_ROWS, 0));
        send_item(make_read(0, SCREEN_COLUMNS));
        send_item(make_read(31, 127));
        send_item(make_write(CODE_BACKSPACE));
        send_item(make_write(8'h00));
        send_item(make_write(8'hFF));
        send_item(make_write(8'h41));
        send_item(make_write(CODE_BACKSPACE));
        send_item(make_read(0, 2));
        send_item(make_read(0, 1));
        send_item(make_read(0, 0));
        send_item(make_write(CODE_NEWLINE));
        send_item(make_write(8'h1B));
        send_item(make_read(1, 0));
        send_item(make_write(CODE_NEWLINE));
        send_item(make_read(1, 1));
        settle();

        // Random phases, each with its own attribute; each pair shares an idling pattern
        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0: begin
                    send_idle_pct = 25;
                    take_stall_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    take_stall_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    take_stall_pct = 0;
                end
            endcase
            program_attribute(attr_plan[p]);
            run_text_phase(PHASE_ITEMS);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d items, %0d results, %0d cell reads, %0d scrolls",
                 sb.items_taken, sb.reports_seen, sb.cell_reads, sb.scrolls);
        $display("summary: %0d attribute settings, %0d mismatches",
                 settings_used, sb.errors + config_errors);
        if (sb.errors == 0 && config_errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/ttcs_pkg.sv
hw/rtl/ttcs_ram.sv
hw/rtl/text_terminal_cursor_scroll_top.sv
tb/text_terminal_cursor_scroll_top_test.sv
